// ===== sv/krsm_pkg.sv =====
// krsm_pkg: shared types, constants and field widths for the slot mapper.
// Used by krsm_ctrl, krsm_datapath and keyed_ragged_slot_mapper.
`timescale 1ns / 1ps

package krsm_pkg;

    // Default sizing of the entry table
    localparam int ENTRIES_DEF  = 64;
    localparam int KEY_BITS_DEF = 32;

    // Fixed field widths of the stream words
    localparam int OP_BITS      = 2;
    localparam int IDX_BITS     = 7;
    localparam int KEY_IN_BITS  = 32;
    localparam int OFS_BITS     = 32;
    localparam int CNT_BITS     = 16;
    localparam int SLOT_BITS    = 32;
    localparam int KEY_MAX_BITS = 64;
    localparam int IN_TDATA_BITS  = 136;
    localparam int OUT_TDATA_BITS = 32;

    // Operation codes carried on s_tuser
    localparam logic [OP_BITS-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_RESOLVE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_SEARCH  = 2'd2;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_SCAN,
        ST_RD_ENTRY,
        ST_RD_NEXT,
        ST_MUL,
        ST_CHECK,
        ST_FAIL,
        ST_DONE
    } state_t;

    // Source of the result registers
    typedef enum logic [1:0] {
        RES_FAIL,
        RES_WRITE,
        RES_CHECK
    } res_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     capture;
        logic     write_en;
        logic     scan_step;
        logic     idx_from_scan;
        logic     next_rd;
        logic     mul_en;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               idx_live;
        logic               scan_hit;
        logic               scan_done;
        logic               out_free;
    } dp_status_t;

endpackage

// ===== sv/keyed_ragged_slot_mapper.sv =====
// keyed_ragged_slot_mapper: top level, joins controller and datapath.
// Depends on krsm_pkg, krsm_ctrl, krsm_datapath (and krsm_ram below it).
`timescale 1ns / 1ps

// Table of ENTRIES entries (key, start offset, action count, combo count) plus
// one closing offset, held in two single-port RAMs. One word is taken at a time
// and answers with one word: slot = start + action*combos + combo, or slot 0
// with status 1 on any failed check. A resolve reads the entry, then the
// closing offset, multiplies and checks; a key search first scans the table,
// since the entry RAM port reads one stored key per cycle.
// The next word is taken once the result has moved into the output register.
// Stores hold no defined contents until written; entry_count resets to zero.
module keyed_ragged_slot_mapper
    import krsm_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // entry_count register
    input  logic                      cfg_wr_en,
    input  logic [IDX_BITS-1:0]       cfg_wr_data,
    // input words
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // entry_index, entry_key, start_offset, action_total, combo_total,
    // action_number, combo_number, zero pad bit
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    // operation
    input  logic [OP_BITS-1:0]        s_tuser,
    // result words
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // slot
    output logic [OUT_TDATA_BITS-1:0] m_tdata,
    // status
    output logic [0:0]                m_tuser
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    krsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    krsm_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== sv/krsm_ram.sv =====
// krsm_ram: generic single-port RAM, read-first, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module krsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One access per cycle: optional write, old contents read out
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/krsm_ctrl.sv =====
// krsm_ctrl: sequencing state machine of the slot mapper.
// Depends on krsm_pkg; drives the command struct of krsm_datapath.
`timescale 1ns / 1ps

module krsm_ctrl
    import krsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.op)
                    OP_WRITE:   state_next = ST_WRITE;
                    OP_RESOLVE: state_next = ST_RD_ENTRY;
                    OP_SEARCH:  state_next = ST_SCAN;
                    default:    state_next = ST_FAIL;
                endcase
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (status.scan_hit)
                begin
                    state_next = ST_RD_ENTRY;
                end
                else if (status.scan_done)
                begin
                    state_next = ST_FAIL;
                end
            end
            ST_RD_ENTRY:
            begin
                state_next = status.idx_live ? ST_RD_NEXT : ST_FAIL;
            end
            ST_RD_NEXT:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_DONE;
            end
            ST_FAIL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        cmd.res_sel = RES_FAIL;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DECODE:
            begin
            end
            ST_WRITE:
            begin
                cmd.write_en = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_WRITE;
            end
            ST_SCAN:
            begin
                cmd.scan_step     = 1'b1;
                cmd.idx_from_scan = status.scan_hit;
            end
            ST_RD_ENTRY:
            begin
            end
            ST_RD_NEXT:
            begin
                cmd.next_rd = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_CHECK;
            end
            ST_FAIL:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_FAIL;
            end
            ST_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sv/krsm_datapath.sv =====
// krsm_datapath: input capture, entry and offset RAMs, scan counter,
// range checks, slot arithmetic and output register.
// Depends on krsm_pkg and krsm_ram.
`timescale 1ns / 1ps

module krsm_datapath
    import krsm_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [IDX_BITS-1:0]       cfg_wr_data,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    input  logic [OP_BITS-1:0]        s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,
    output logic [0:0]                m_tuser,
    input  ctrl_cmd_t                 cmd,
    output dp_status_t                status
);

    localparam int ENT_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OFS_AW = $clog2(ENTRIES + 1);
    localparam int XW     = (OFS_AW > IDX_BITS) ? OFS_AW : IDX_BITS;
    localparam int ENT_W  = KEY_BITS + 2 * CNT_BITS;
    localparam logic [XW-1:0] ENT_LIM = XW'(ENTRIES);

    // Unpacked input word
    logic [IDX_BITS-1:0]     in_idx;
    logic [KEY_IN_BITS-1:0]  in_key;
    logic [KEY_MAX_BITS-1:0] in_key_wide;
    logic [OFS_BITS-1:0]     in_start;
    logic [CNT_BITS-1:0]     in_atot;
    logic [CNT_BITS-1:0]     in_ctot;
    logic [CNT_BITS-1:0]     in_act;
    logic [CNT_BITS-1:0]     in_cmb;

    assign in_idx      = s_tdata[6:0];
    assign in_key      = s_tdata[38:7];
    assign in_start    = s_tdata[70:39];
    assign in_atot     = s_tdata[86:71];
    assign in_ctot     = s_tdata[102:87];
    assign in_act      = s_tdata[118:103];
    assign in_cmb      = s_tdata[134:119];
    assign in_key_wide = {{(KEY_MAX_BITS - KEY_IN_BITS){1'b0}}, in_key};

    // Captured word
    logic [OP_BITS-1:0]  op_reg;
    logic [XW-1:0]       idx_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [OFS_BITS-1:0] start_reg;
    logic [CNT_BITS-1:0] atot_reg;
    logic [CNT_BITS-1:0] ctot_reg;
    logic [CNT_BITS-1:0] act_reg;
    logic [CNT_BITS-1:0] cmb_reg;

    // Configuration and scan state
    logic [IDX_BITS-1:0] entry_count_reg;
    logic [XW-1:0]       live;
    logic [XW-1:0]       count_x;
    logic [XW-1:0]       scan_cnt_reg;
    logic [XW-1:0]       pend_idx_reg;
    logic                pend_valid_reg;
    logic                scan_more;

    // Entry fields read back and check pipeline
    logic [KEY_BITS-1:0]   ent_key_reg;
    logic [CNT_BITS-1:0]   acts_reg;
    logic [CNT_BITS-1:0]   cmbs_reg;
    logic [OFS_BITS-1:0]   begin_reg;
    logic [OFS_BITS-1:0]   len_reg;
    logic [2*CNT_BITS-1:0] prod_reg;
    logic                  basic_ok_reg;
    logic                  res_ok_reg;
    logic [SLOT_BITS-1:0]  res_slot_reg;

    // Output register
    logic                  m_tvalid_reg;
    logic [SLOT_BITS-1:0]  slot_out_reg;
    logic                  status_out_reg;

    // RAM ports
    logic                  ent_we;
    logic [ENT_AW-1:0]     ent_addr;
    logic [ENT_W-1:0]      ent_wdata;
    logic [ENT_W-1:0]      ent_rdata;
    logic [KEY_BITS-1:0]   rd_key;
    logic                  ofs_we;
    logic [OFS_AW-1:0]     ofs_addr;
    logic [OFS_BITS-1:0]   ofs_rdata;
    logic [XW-1:0]         idx_plus;

    // Check arithmetic
    logic [OFS_BITS:0]     diff;
    logic                  basic_ok_next;
    logic [SLOT_BITS:0]    rel;
    logic                  check_ok;
    logic [SLOT_BITS-1:0]  check_slot;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    // Live count: an oversized count acts as the table size
    assign count_x   = XW'(entry_count_reg);
    assign live      = (count_x > ENT_LIM) ? ENT_LIM : count_x;
    assign scan_more = scan_cnt_reg < live;

    // Capture the input word; a scan hit replaces the index
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= s_tuser;
            idx_reg   <= XW'(in_idx);
            key_reg   <= in_key_wide[KEY_BITS-1:0];
            start_reg <= in_start;
            atot_reg  <= in_atot;
            ctot_reg  <= in_ctot;
            act_reg   <= in_act;
            cmb_reg   <= in_cmb;
        end
        else if (cmd.idx_from_scan)
        begin
            idx_reg <= pend_idx_reg;
        end
    end

    // Scan counter: issues one entry read a cycle, compares the key in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            scan_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            pend_valid_reg <= scan_more;
            if (scan_more)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            pend_idx_reg <= scan_cnt_reg;
        end
    end

    // Entry RAM: key, action count, combo count
    assign ent_we    = cmd.write_en && (idx_reg < ENT_LIM);
    assign ent_addr  = cmd.scan_step ? scan_cnt_reg[ENT_AW-1:0] : idx_reg[ENT_AW-1:0];
    assign ent_wdata = {key_reg, atot_reg, ctot_reg};
    assign rd_key    = ent_rdata[ENT_W-1:2*CNT_BITS];

    krsm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES),
        .AW    (ENT_AW)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_we),
        .addr    (ent_addr),
        .wr_data (ent_wdata),
        .rd_data (ent_rdata)
    );

    // Offset RAM: one extra entry closes the last range
    assign idx_plus = idx_reg + 1'b1;
    assign ofs_we   = cmd.write_en && (idx_reg <= ENT_LIM);
    assign ofs_addr = cmd.next_rd ? idx_plus[OFS_AW-1:0] : idx_reg[OFS_AW-1:0];

    krsm_ram #(
        .WIDTH (OFS_BITS),
        .DEPTH (ENTRIES + 1),
        .AW    (OFS_AW)
    ) u_offset_ram (
        .clk     (clk),
        .wr_en   (ofs_we),
        .addr    (ofs_addr),
        .wr_data (start_reg),
        .rd_data (ofs_rdata)
    );

    // Latch the entry and its start offset
    always_ff @(posedge clk)
    begin
        if (cmd.next_rd)
        begin
            ent_key_reg <= rd_key;
            acts_reg    <= ent_rdata[2*CNT_BITS-1:CNT_BITS];
            cmbs_reg    <= ent_rdata[CNT_BITS-1:0];
            begin_reg   <= ofs_rdata;
        end
    end

    // First check stage: range length, key and count checks and product
    assign diff = {1'b0, ofs_rdata} - {1'b0, begin_reg};
    assign basic_ok_next = (ent_key_reg == key_reg) && !diff[OFS_BITS]
                         && (acts_reg != '0) && (cmbs_reg != '0)
                         && (act_reg < acts_reg) && (cmb_reg < cmbs_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            len_reg      <= diff[OFS_BITS-1:0];
            prod_reg     <= act_reg * cmbs_reg;
            basic_ok_reg <= basic_ok_next;
        end
    end

    // Second check stage; rel below the length keeps begin + rel under the
    // closing offset, so the slot cannot pass the 32-bit limit
    assign rel        = {1'b0, prod_reg} + (SLOT_BITS + 1)'(cmb_reg);
    assign check_ok   = basic_ok_reg && (rel < {1'b0, len_reg});
    assign check_slot = begin_reg + rel[SLOT_BITS-1:0];

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_WRITE:
                begin
                    res_ok_reg   <= (idx_reg <= ENT_LIM);
                    res_slot_reg <= '0;
                end
                RES_CHECK:
                begin
                    res_ok_reg   <= check_ok;
                    res_slot_reg <= check_ok ? check_slot : '0;
                end
                default:
                begin
                    res_ok_reg   <= 1'b0;
                    res_slot_reg <= '0;
                end
            endcase
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            slot_out_reg   <= res_slot_reg;
            status_out_reg <= !res_ok_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = slot_out_reg;
    assign m_tuser[0] = status_out_reg;

    // Status to the controller
    assign status.op        = op_reg;
    assign status.idx_live  = idx_reg < live;
    assign status.scan_hit  = pend_valid_reg && (rd_key == key_reg);
    assign status.scan_done = !pend_valid_reg && !scan_more;
    assign status.out_free  = !m_tvalid_reg || m_tready;

endmodule
